// ----- design/demand_paged_memory_manager_core_macros.svh -----
`ifndef DEMAND_PAGED_MEMORY_MANAGER_CORE_MACROS_SVH
`define DEMAND_PAGED_MEMORY_MANAGER_CORE_MACROS_SVH
// assertion helpers
`define DPMM_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("dpmm check failed");
`define DPMM_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("dpmm check failed");
`endif

// ----- design/dpmm_pkg.sv -----
package dpmm_pkg;
   localparam int PROC_SLOTS = 8;
   localparam int PAGE_BYTES = 64;
   localparam int PHYS_BYTES = 4096;
   localparam int VIRT_BYTES = 1024;
   localparam int VPAGES = (VIRT_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int FRAMES = PHYS_BYTES / PAGE_BYTES;
   localparam int SLOT_W = $clog2(PROC_SLOTS) > 0 ? $clog2(PROC_SLOTS) : 1;
   localparam int VP_W = $clog2(VPAGES) > 0 ? $clog2(VPAGES) : 1;
   localparam int FR_W = $clog2(FRAMES) > 0 ? $clog2(FRAMES) : 1;
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam int PA_W = FR_W + OFF_W;
   localparam int PT_W = SLOT_W + VP_W;
   localparam int RES_W = $clog2(FRAMES + VPAGES + 1);

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0, CMD_READ = 2'd1, CMD_WRITE = 2'd2, CMD_EXIT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_NO_SLOT = 3'd1, ST_NO_SPACE = 3'd2, ST_TOO_LARGE = 3'd3,
      ST_BAD_PID = 3'd4, ST_RANGE = 3'd5, ST_NO_FRAME = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  proc_id;
      logic [9:0]  vaddr;
      logic [10:0] request_size;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] new_pid;
      logic [7:0] rdata;
   } rsp_type;

   typedef struct packed {
      logic          we;
      logic [PT_W-1:0] addr;
      logic          present;
      logic [FR_W-1:0] frame;
   } pt_port_type;

   typedef struct packed {
      logic          we;
      logic [PA_W-1:0] addr;
      logic [7:0]    data;
   } pm_port_type;
endpackage

// ----- design/demand_paged_memory_manager_core.sv -----
// Demand-paged memory manager: one word in, one result word out, one item at a time.
// Reset clears the 4096-byte physical store in a sweep over every byte, with
// req_ready low throughout. A write to a mapped page steps through decode,
// page-table read, page-table wait and access before the result word; a read
// adds a wait for the byte store. Mapping a missing page adds a map step, and a
// read that maps one clears its frame first. A rejected command answers straight
// from decode. Create writes every page-table entry of its slot and then answers;
// exit walks the slot's pages, freeing each mapped frame, and then answers.
// The next request word can be taken from the cycle after the result word leaves.
// The page-table and byte-store ports allow one access each per cycle.
module demand_paged_memory_manager_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dpmm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpmm_pkg::rsp_type rsp_data
);
   import dpmm_pkg::*;

   pt_port_type   pt_port;
   pm_port_type   pm_port;
   logic [FR_W:0] pt_rdata;
   logic [7:0]    pm_rdata;

   dpmm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .pt_port, .pt_rdata, .pm_port, .pm_rdata
   );

   dpmm_ram #(.WIDTH(FR_W + 1), .DEPTH(PROC_SLOTS * (1 << VP_W))) u_page_table (
      .clock, .we(pt_port.we), .addr(pt_port.addr),
      .wdata({pt_port.present, pt_port.frame}), .rdata(pt_rdata)
   );

   dpmm_ram #(.WIDTH(8), .DEPTH(1 << PA_W)) u_phys_mem (
      .clock, .we(pm_port.we), .addr(pm_port.addr),
      .wdata(pm_port.data), .rdata(pm_rdata)
   );
endmodule

// ----- design/dpmm_ram.sv -----
module dpmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/dpmm_ctrl.sv -----
module dpmm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dpmm_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dpmm_pkg::rsp_type           rsp_data,
   output dpmm_pkg::pt_port_type       pt_port,
   input  logic [dpmm_pkg::FR_W:0]     pt_rdata,
   output dpmm_pkg::pm_port_type       pm_port,
   input  logic [7:0]                  pm_rdata
);
   import dpmm_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_PTREAD, S_PTWAIT, S_MAP, S_ZERO, S_ACCESS,
      S_RDWAIT, S_INIT, S_EXITRD, S_EXITWAIT, S_RESP
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic [PROC_SLOTS-1:0] running_ff, running_in;
   logic [10:0] bytes_ff [PROC_SLOTS];
   logic [10:0] bytes_wr;
   logic bytes_we;
   logic [FRAMES-1:0] used_ff, used_in;
   logic [RES_W-1:0] resv_ff, resv_in;
   logic [PA_W:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FR_W-1:0] frame_ff, frame_in;
   logic valid_ff, valid_in;

   logic [SLOT_W-1:0] free_slot;
   logic              have_slot;
   logic [FR_W-1:0]   free_frame;
   logic              have_frame;
   logic [SLOT_W-1:0] pid;
   logic              pid_ok;
   logic [VP_W-1:0]   vpage;
   logic [OFF_W-1:0]  voff;
   logic [VP_W:0]     size_pages;

   always_comb begin
      free_slot = '0;
      have_slot = 1'b0;
      for (int i = PROC_SLOTS - 1; i >= 0; i--) begin
         if (!running_ff[i]) begin
            free_slot = SLOT_W'(i);
            have_slot = 1'b1;
         end
      end
      free_frame = '0;
      have_frame = 1'b0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_frame = FR_W'(i);
            have_frame = 1'b1;
         end
      end
   end

   assign pid    = req_ff.proc_id[SLOT_W-1:0];
   assign pid_ok = (32'(req_ff.proc_id) < PROC_SLOTS) && running_ff[pid];
   assign vpage  = VP_W'(req_ff.vaddr / PAGE_BYTES);
   assign voff   = OFF_W'(req_ff.vaddr % PAGE_BYTES);
   assign size_pages = (VP_W+1)'((32'(bytes_ff[slot_ff]) + PAGE_BYTES - 1) / PAGE_BYTES);

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      running_in = running_ff;
      used_in    = used_ff;
      resv_in    = resv_ff;
      cnt_in     = cnt_ff;
      slot_in    = slot_ff;
      frame_in   = frame_ff;
      valid_in   = valid_ff;
      bytes_we   = 1'b0;
      bytes_wr   = '0;
      pt_port    = '0;
      pm_port    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            pm_port.we   = 1'b1;
            pm_port.addr = cnt_ff[PA_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[PA_W-1:0] == PA_W'(PHYS_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rsp_in   = '0;
            state_in = S_RESP;
            slot_in  = pid;
            unique case (cmd_type'(req_ff.cmd))
               CMD_CREATE: begin
                  if (!have_slot) begin
                     rsp_in.status = ST_NO_SLOT;
                  end else if (32'(resv_ff) * PAGE_BYTES + 32'(req_ff.request_size)
                               > PHYS_BYTES) begin
                     rsp_in.status = ST_NO_SPACE;
                  end else if (32'(req_ff.request_size) > VIRT_BYTES) begin
                     rsp_in.status = ST_TOO_LARGE;
                  end else begin
                     slot_in   = free_slot;
                     cnt_in    = '0;
                     state_in  = S_INIT;
                  end
               end
               CMD_READ, CMD_WRITE: begin
                  if (!pid_ok) begin
                     rsp_in.status = ST_BAD_PID;
                  end else if (11'(req_ff.vaddr) >= bytes_ff[pid]) begin
                     rsp_in.status = ST_RANGE;
                  end else begin
                     state_in = S_PTREAD;
                  end
               end
               CMD_EXIT: begin
                  if (!pid_ok) begin
                     rsp_in.status = ST_BAD_PID;
                  end else begin
                     cnt_in   = '0;
                     state_in = S_EXITRD;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_INIT: begin
            pt_port.we   = 1'b1;
            pt_port.addr = {slot_ff, cnt_ff[VP_W-1:0]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[VP_W-1:0] == VP_W'(VPAGES - 1)) begin
               bytes_we = 1'b1;
               bytes_wr = req_ff.request_size;
               resv_in  = resv_ff + RES_W'((32'(req_ff.request_size) + PAGE_BYTES - 1)
                                           / PAGE_BYTES);
               running_in[slot_ff] = 1'b1;
               rsp_in.new_pid = 3'(slot_ff);
               state_in = S_RESP;
            end
         end
         S_PTREAD: begin
            pt_port.addr = {slot_ff, vpage};
            state_in = S_PTWAIT;
         end
         S_PTWAIT: begin
            if (pt_rdata[FR_W]) begin
               frame_in = pt_rdata[FR_W-1:0];
               state_in = S_ACCESS;
            end else if (!have_frame) begin
               rsp_in.status = ST_NO_FRAME;
               state_in = S_RESP;
            end else begin
               frame_in = free_frame;
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            pt_port.we      = 1'b1;
            pt_port.addr    = {slot_ff, vpage};
            pt_port.present = 1'b1;
            pt_port.frame   = frame_ff;
            used_in[frame_ff] = 1'b1;
            cnt_in = '0;
            state_in = (cmd_type'(req_ff.cmd) == CMD_READ) ? S_ZERO : S_ACCESS;
         end
         S_ZERO: begin
            pm_port.we   = 1'b1;
            pm_port.addr = {frame_ff, cnt_ff[OFF_W-1:0]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[OFF_W-1:0] == OFF_W'(PAGE_BYTES - 1)) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            pm_port.addr = {frame_ff, voff};
            if (cmd_type'(req_ff.cmd) == CMD_WRITE) begin
               pm_port.we   = 1'b1;
               pm_port.data = req_ff.wdata;
               state_in = S_RESP;
            end else begin
               state_in = S_RDWAIT;
            end
         end
         S_RDWAIT: begin
            rsp_in.rdata = pm_rdata;
            state_in = S_RESP;
         end
         S_EXITRD: begin
            if (32'(cnt_ff) >= VPAGES || cnt_ff[VP_W:0] >= size_pages) begin
               resv_in  = (resv_ff >= RES_W'(size_pages)) ? resv_ff - RES_W'(size_pages)
                                                           : '0;
               bytes_we = 1'b1;
               bytes_wr = '0;
               running_in[slot_ff] = 1'b0;
               state_in = S_RESP;
            end else begin
               pt_port.addr = {slot_ff, cnt_ff[VP_W-1:0]};
               state_in = S_EXITWAIT;
            end
         end
         S_EXITWAIT: begin
            if (pt_rdata[FR_W]) begin
               used_in[pt_rdata[FR_W-1:0]] = 1'b0;
            end
            pt_port.we   = 1'b1;
            pt_port.addr = {slot_ff, cnt_ff[VP_W-1:0]};
            cnt_in = cnt_ff + 1'b1;
            state_in = S_EXITRD;
         end
         S_RESP: begin
            valid_in = 1'b1;
            if (valid_ff && rsp_ready) begin
               valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         running_ff <= '0;
         used_ff    <= '0;
         resv_ff    <= '0;
         cnt_ff     <= '0;
         valid_ff   <= 1'b0;
         for (int i = 0; i < PROC_SLOTS; i++) begin
            bytes_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         running_ff <= running_in;
         used_ff    <= used_in;
         resv_ff    <= resv_in;
         cnt_ff     <= cnt_in;
         valid_ff   <= valid_in;
         if (bytes_we) begin
            bytes_ff[slot_ff] <= bytes_wr;
         end
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      slot_ff   <= slot_in;
      frame_ff  <= frame_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- design/dpmm_checker.sv -----
`include "demand_paged_memory_manager_core_macros.svh"
module dpmm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input dpmm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dpmm_pkg::rsp_type rsp_data
);
   import dpmm_pkg::*;

   `DPMM_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, !req_ready)
   `DPMM_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_data.status <= ST_NO_FRAME)
   `DPMM_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.new_pid == 3'd0 && rsp_data.rdata == 8'd0)
   `DPMM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule

bind demand_paged_memory_manager_core dpmm_checker u_dpmm_checker (.*);
